### hw/rtl/ordered_list_store_top_assert.svh
// assertion macros for the ordered list store
`ifndef ORDERED_LIST_STORE_TOP_ASSERT_SVH
`define ORDERED_LIST_STORE_TOP_ASSERT_SVH

`ifndef SYNTHESIS

// antecedent implies consequent in the same cycle
`define OLST_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// antecedent implies consequent in the next cycle
`define OLST_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define OLST_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define OLST_ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

### hw/rtl/olst_pkg.sv
// types and constants shared by the ordered list store
package olst_pkg;

    localparam int CAPACITY = 16;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int VAL_W    = 32;
    localparam int POS_W    = 5;
    localparam int FIDX_W   = 4;
    localparam int LEN_W    = 5;

    typedef enum logic [2:0] {
        KIND_INS_FRONT = 3'd0,
        KIND_INS_AT    = 3'd1,
        KIND_INS_END   = 3'd2,
        KIND_DEL_FRONT = 3'd3,
        KIND_DEL_AT    = 3'd4,
        KIND_DEL_END   = 3'd5,
        KIND_DEL_VALUE = 3'd6,
        KIND_SEARCH    = 3'd7
    } t_kind;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_EMPTY    = 3'd1,
        ST_RANGE    = 3'd2,
        ST_NOTFOUND = 3'd3,
        ST_FULL     = 3'd4
    } t_status;

    typedef logic [VAL_W-1:0] t_word;

    typedef struct packed {
        t_kind                     kind;
        logic signed [VAL_W-1:0]   item_value;
        logic        [POS_W-1:0]   position;
    } t_req;

    typedef struct packed {
        t_status                   status;
        logic signed [VAL_W-1:0]   found_value;
        logic        [FIDX_W-1:0]  found_index;
        logic        [LEN_W-1:0]   length;
    } t_rsp;

    // broadcast to every cell of the chain
    typedef struct packed {
        logic              ins;
        logic              del;
        logic [IDX_W-1:0]  idx;
        t_word             value;
    } t_cell_ctrl;

endpackage

### hw/rtl/olst_cell.sv
// one storage cell of the list chain
module olst_cell (
    input  logic                                i_clk,
    input  olst_pkg::t_cell_ctrl                i_ctrl,
    input  logic [olst_pkg::IDX_W-1:0]          i_pos,
    input  logic [olst_pkg::CNT_W-1:0]          i_count,
    input  olst_pkg::t_word                     i_left,
    input  olst_pkg::t_word                     i_right,
    output olst_pkg::t_word                     o_value,
    output logic                                o_match
);
    import olst_pkg::*;

    t_word r_value;
    t_word n_value;

    always_comb begin
        n_value = r_value;
        if (i_ctrl.ins) begin
            if (i_pos == i_ctrl.idx) begin
                n_value = i_ctrl.value;
            end else if (i_pos > i_ctrl.idx) begin
                n_value = i_left;
            end
        end else if (i_ctrl.del) begin
            if (i_pos >= i_ctrl.idx) begin
                n_value = i_right;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    // only cells holding a live entry can match
    assign o_match = (CNT_W'(i_pos) < i_count) && (r_value == i_ctrl.value);
    assign o_value = r_value;

endmodule

### hw/rtl/olst_ctrl.sv
// request decode, length counter and result register
module olst_ctrl (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_accept,
    input  olst_pkg::t_req                      i_req,
    input  olst_pkg::t_word [olst_pkg::CAPACITY-1:0] i_values,
    input  logic [olst_pkg::CAPACITY-1:0]       i_match,
    output olst_pkg::t_cell_ctrl                o_ctrl,
    output logic [olst_pkg::CNT_W-1:0]          o_count,
    output logic                                o_done,
    output olst_pkg::t_rsp                      o_rsp
);
    import olst_pkg::*;

    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             r_done;
    t_rsp             r_rsp;
    t_rsp             n_rsp;

    logic             full;
    logic             empty;
    logic             hit;
    logic [IDX_W-1:0] hit_idx;
    logic [IDX_W-1:0] idx;
    t_status          status;
    logic             do_ins;
    logic             do_del;
    logic             ok;

    assign full  = (r_count >= CNT_W'(CAPACITY));
    assign empty = (r_count == '0);

    // first live match, lowest index wins
    always_comb begin
        hit     = 1'b0;
        hit_idx = '0;
        for (int i = CAPACITY - 1; i >= 0; i--) begin
            if (i_match[i]) begin
                hit     = 1'b1;
                hit_idx = IDX_W'(i);
            end
        end
    end

    always_comb begin
        status = ST_OK;
        idx    = '0;
        do_ins = 1'b0;
        do_del = 1'b0;
        unique case (i_req.kind) inside
            KIND_INS_FRONT, KIND_INS_AT, KIND_INS_END: begin
                if (full) begin
                    status = ST_FULL;
                end else if (i_req.kind == KIND_INS_AT &&
                             32'(i_req.position) > 32'(r_count)) begin
                    status = ST_RANGE;
                end else begin
                    do_ins = 1'b1;
                    if (i_req.kind == KIND_INS_END) begin
                        idx = IDX_W'(r_count);
                    end else if (i_req.kind == KIND_INS_AT) begin
                        idx = IDX_W'(i_req.position);
                    end
                end
            end
            KIND_DEL_FRONT: begin
                if (empty) status = ST_EMPTY;
                else       do_del = 1'b1;
            end
            KIND_DEL_AT: begin
                if (empty) begin
                    status = ST_EMPTY;
                end else if (32'(i_req.position) >= 32'(r_count)) begin
                    status = ST_RANGE;
                end else begin
                    do_del = 1'b1;
                    idx    = IDX_W'(i_req.position);
                end
            end
            KIND_DEL_END: begin
                if (empty) begin
                    status = ST_EMPTY;
                end else begin
                    do_del = 1'b1;
                    idx    = IDX_W'(r_count - CNT_W'(1));
                end
            end
            KIND_DEL_VALUE, KIND_SEARCH: begin
                if (empty) begin
                    status = ST_EMPTY;
                end else if (!hit) begin
                    status = ST_NOTFOUND;
                end else begin
                    do_del = (i_req.kind == KIND_DEL_VALUE);
                    idx    = hit_idx;
                end
            end
            default: status = ST_OK;
        endcase
    end

    assign ok = (status == ST_OK);

    always_comb begin
        n_count = r_count;
        if (i_accept && do_ins) n_count = r_count + CNT_W'(1);
        if (i_accept && do_del) n_count = r_count - CNT_W'(1);
    end

    always_comb begin
        n_rsp.status      = status;
        n_rsp.found_value = '0;
        n_rsp.found_index = '0;
        n_rsp.length      = LEN_W'(n_count);
        if (ok) begin
            n_rsp.found_value = do_ins ? i_req.item_value : i_values[idx];
            n_rsp.found_index = FIDX_W'(idx);
        end
    end

    assign o_ctrl.ins   = i_accept && do_ins;
    assign o_ctrl.del   = i_accept && do_del;
    assign o_ctrl.idx   = idx;
    assign o_ctrl.value = i_req.item_value;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_count <= n_count;
            r_done  <= i_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) r_rsp <= n_rsp;
    end

    assign o_count = r_count;
    assign o_done  = r_done;
    assign o_rsp   = r_rsp;

endmodule

### hw/rtl/ordered_list_store_top.sv
// ordered list store: bounded list of signed words held in a shifting cell chain
// result: the result beat appears in the cycle after start is taken, strobed by o_done
// throughput: one request per cycle, busy stays low; set by the compare-and-shift
//   that acts across all cells of the chain
// reset: synchronous active-low i_rst_n empties the list (length zero); cell contents
//   are not cleared, entries past the length are never read
module ordered_list_store_top (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    output logic            busy,
    input  olst_pkg::t_req  i_req,
    output logic            o_done,
    output olst_pkg::t_rsp  o_rsp
);
    import olst_pkg::*;

    `include "ordered_list_store_top_assert.svh"

    // busy is tied low, so the block never holds off start
    logic                       accept;
    t_cell_ctrl                 cell_ctrl;
    logic [CNT_W-1:0]           count;
    t_word [CAPACITY-1:0]       values;
    logic  [CAPACITY-1:0]       match;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    // decode, pick the index to act on, keep the length and register the result
    olst_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_req    (i_req),
        .i_values (values),
        .i_match  (match),
        .o_ctrl   (cell_ctrl),
        .o_count  (count),
        .o_done   (o_done),
        .o_rsp    (o_rsp)
    );

    // the chain: on insert the cell at the index takes the value, cells past it take
    // from the left, on delete at and past it from the right; all cells compare the key
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        t_word left;
        t_word right;

        if (g == 0) begin : g_head
            assign left = cell_ctrl.value;      // never selected at the head
        end else begin : g_body
            assign left = values[g-1];
        end

        if (g == CAPACITY - 1) begin : g_tail
            assign right = values[g];           // tail entry leaves the list on delete
        end else begin : g_mid
            assign right = values[g+1];
        end

        olst_cell u_cell (
            .i_clk   (i_clk),
            .i_ctrl  (cell_ctrl),
            .i_pos   (IDX_W'(g)),
            .i_count (count),
            .i_left  (left),
            .i_right (right),
            .o_value (values[g]),
            .o_match (match[g])
        );
    end

    // a result beat comes in the cycle after each accepted request, and only then
    `OLST_ASSERT_NXT(a_done_follows, i_clk, i_rst_n, accept, o_done)
    `OLST_ASSERT_IMP(a_done_has_cause, i_clk, i_rst_n, o_done, $past(accept))
    // the list never holds more than its capacity
    `OLST_ASSERT_IMP(a_len_bound, i_clk, i_rst_n, 1'b1, count <= CNT_W'(CAPACITY))
    // a failed request leaves the length alone
    `OLST_ASSERT_IMP(a_fail_keeps_len, i_clk, i_rst_n,
        o_done && o_rsp.status != ST_OK, count == $past(count))

endmodule

### bench/ordered_list_store_top_tb.sv
// self-checking bench for the ordered list store: directed edge cases, then grow/shrink traffic
module ordered_list_store_top_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import olst_pkg::*;

    localparam int RESET_CYCLES = 12;
    localparam int QUIET_LIMIT  = 2000;   // cycles with no beat in either direction
    localparam int TAIL_CYCLES  = 4;      // result arrives in the cycle after start is taken, keep a margin
    localparam int PHASE_ITEMS  = 40;
    localparam int ROUNDS       = 8;
    localparam int PRINT_CAP    = 50;

    logic  i_clk   = 1'b0;
    logic  i_rst_n = 1'b0;
    logic  start   = 1'b0;
    logic  busy;
    t_req  i_req   = '0;
    logic  o_done;
    t_rsp  o_rsp;

    // shadow copy of the list, updated as each request beat is taken
    t_word       shadow_cells [CAPACITY];
    int unsigned shadow_len  = 0;
    t_rsp        pending_rsp [$];
    int unsigned error_count = 0;
    int unsigned quiet_cycles = 0;
    int unsigned gap_cap     = 0;

    ordered_list_store_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_req   (i_req),
        .o_done  (o_done),
        .o_rsp   (o_rsp)
    );

    // 12 ns period
    always begin
        #6;
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
    end

    // expected response for one request, applied to the shadow list
    function automatic t_rsp apply_request(t_req req);
        t_rsp        rsp;
        int unsigned at;
        int unsigned i;
        bit          hit;
        rsp        = '0;
        rsp.status = ST_OK;
        at         = 0;
        hit        = 1'b0;
        case (req.kind)
            KIND_INS_FRONT, KIND_INS_AT, KIND_INS_END: begin
                // full check wins over the index check
                if (shadow_len >= CAPACITY) begin
                    rsp.status = ST_FULL;
                end else if (req.kind == KIND_INS_AT && req.position > shadow_len) begin
                    rsp.status = ST_RANGE;
                end else begin
                    if (req.kind == KIND_INS_FRONT)
                        at = 0;
                    else if (req.kind == KIND_INS_END)
                        at = shadow_len;
                    else
                        at = req.position;
                    for (i = shadow_len; i > at; i--)
                        shadow_cells[i] = shadow_cells[i - 1];
                    shadow_cells[at] = req.item_value;
                    shadow_len++;
                    rsp.found_value = req.item_value;
                    rsp.found_index = FIDX_W'(at);
                end
            end
            default: begin
                if (shadow_len == 0) begin
                    rsp.status = ST_EMPTY;
                end else begin
                    case (req.kind)
                        KIND_DEL_FRONT: begin
                            at  = 0;
                            hit = 1'b1;
                        end
                        KIND_DEL_AT: begin
                            if (req.position < shadow_len) begin
                                at  = req.position;
                                hit = 1'b1;
                            end else begin
                                rsp.status = ST_RANGE;
                            end
                        end
                        KIND_DEL_END: begin
                            at  = shadow_len - 1;
                            hit = 1'b1;
                        end
                        default: begin
                            // first match from the front
                            for (i = 0; i < shadow_len; i++) begin
                                if (!hit && shadow_cells[i] == req.item_value) begin
                                    at  = i;
                                    hit = 1'b1;
                                end
                            end
                            if (!hit)
                                rsp.status = ST_NOTFOUND;
                        end
                    endcase
                    if (hit) begin
                        rsp.found_value = shadow_cells[at];
                        rsp.found_index = FIDX_W'(at);
                        if (req.kind != KIND_SEARCH) begin
                            for (i = at; i + 1 < shadow_len; i++)
                                shadow_cells[i] = shadow_cells[i + 1];
                            shadow_len--;
                        end
                    end
                end
            end
        endcase
        rsp.length = LEN_W'(shadow_len);
        return rsp;
    endfunction

    task automatic report_mismatch(string msg);
        error_count++;
        if (error_count <= PRINT_CAP)
            $display("mismatch at %0t: %s", $time, msg);
    endtask

    // one request beat: random gap, then hold start until taken
    task automatic issue_request(t_kind kind, t_word value, logic [POS_W-1:0] pos);
        t_req        req;
        int unsigned gap;
        req.kind       = kind;
        req.item_value = value;
        req.position   = pos;
        gap = $urandom_range(0, gap_cap);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_req <= req;
        do @(posedge i_clk); while (busy);
        pending_rsp.push_back(apply_request(req));
    endtask

    // hold off the sender until every response beat is back
    task automatic wait_for_results();
        start <= 1'b0;
        do @(posedge i_clk); while (pending_rsp.size() != 0);
    endtask

    // mostly values already in the list or from a small pool, so matches and duplicates happen
    function automatic t_word pick_value();
        int unsigned r;
        r = $urandom_range(0, 3);
        if (r < 2 && shadow_len > 0)
            return shadow_cells[$urandom_range(0, shadow_len - 1)];
        if (r < 3)
            return t_word'($urandom_range(0, 7)) - t_word'(4);
        return t_word'($urandom);
    endfunction

    // mostly in range, sometimes anywhere in the 5-bit field
    function automatic logic [POS_W-1:0] pick_position();
        if ($urandom_range(0, 3) != 0)
            return POS_W'($urandom_range(0, shadow_len));
        return POS_W'($urandom_range(0, 31));
    endfunction

    function automatic t_kind pick_kind(bit growing);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (growing)
            return (r < 80) ? t_kind'($urandom_range(0, 2)) : t_kind'($urandom_range(3, 7));
        if (r < 8)
            return t_kind'($urandom_range(0, 2));
        if (r < 18)
            return KIND_SEARCH;
        return t_kind'($urandom_range(3, 6));
    endfunction

    // every non-insert request on an empty list, plus an insert past the end
    task automatic test_empty_list();
        issue_request(KIND_DEL_FRONT, 32'h0000_0001, 5'd0);
        issue_request(KIND_DEL_AT,    32'h0000_0000, 5'd31);
        issue_request(KIND_DEL_END,   32'hFFFF_FFFF, 5'd0);
        issue_request(KIND_DEL_VALUE, 32'h0000_0000, 5'd0);
        issue_request(KIND_SEARCH,    32'h8000_0000, 5'd16);
        issue_request(KIND_INS_AT,    32'h0000_0005, 5'd1);
    endtask

    // value extremes, append through insert-at, index bounds on both sides
    task automatic test_insert_delete_edges();
        issue_request(KIND_INS_FRONT, 32'h8000_0000, 5'd0);
        issue_request(KIND_INS_END,   32'h7FFF_FFFF, 5'd31);
        issue_request(KIND_INS_AT,    32'h0000_0000, 5'd1);
        issue_request(KIND_INS_AT,    32'hFFFF_FFFF, 5'd3);
        issue_request(KIND_INS_AT,    32'h0000_0005, 5'd5);
        issue_request(KIND_SEARCH,    32'h7FFF_FFFF, 5'd0);
        issue_request(KIND_SEARCH,    32'h0000_3039, 5'd0);
        issue_request(KIND_DEL_VALUE, 32'h0000_0007, 5'd0);
        issue_request(KIND_DEL_AT,    32'h0000_0000, 5'd4);
        issue_request(KIND_DEL_AT,    32'h0000_0000, 5'd3);
        issue_request(KIND_DEL_VALUE, 32'h0000_0000, 5'd0);
        issue_request(KIND_DEL_END,   32'h0000_0000, 5'd0);
        issue_request(KIND_DEL_FRONT, 32'h0000_0000, 5'd0);
    endtask

    // duplicates: search and delete must hit the first one
    task automatic test_first_match();
        issue_request(KIND_INS_END,   32'd9, 5'd0);
        issue_request(KIND_INS_FRONT, 32'd3, 5'd0);
        issue_request(KIND_INS_END,   32'd9, 5'd0);
        issue_request(KIND_SEARCH,    32'd9, 5'd0);
        issue_request(KIND_DEL_VALUE, 32'd9, 5'd0);
        issue_request(KIND_DEL_VALUE, 32'd9, 5'd0);
        issue_request(KIND_DEL_AT,    32'd0, 5'd0);
    endtask

    // alternating grow and shrink phases: fills to capacity, hits full, drains to empty
    task automatic test_fill_and_drain();
        for (int rnd = 0; rnd < ROUNDS; rnd++) begin
            for (int ph = 0; ph < 2; ph++) begin
                // some phases run back to back with no gaps
                gap_cap = ($urandom_range(0, 2) == 0) ? 0 : 7;
                for (int n = 0; n < PHASE_ITEMS; n++) begin
                    issue_request(pick_kind(ph == 0), pick_value(), pick_position());
                    if ($urandom_range(0, 49) == 0)
                        wait_for_results();
                end
            end
        end
    endtask

    // response beat check against the oldest expectation
    always @(posedge i_clk) begin
        t_rsp want;
        if (i_rst_n && o_done) begin
            if (pending_rsp.size() == 0) begin
                report_mismatch("response beat with no request outstanding");
            end else begin
                want = pending_rsp.pop_front();
                if (o_rsp.status !== want.status)
                    report_mismatch($sformatf("status got %0d want %0d",
                                              o_rsp.status, want.status));
                if (o_rsp.found_value !== want.found_value)
                    report_mismatch($sformatf("found_value got %0d want %0d",
                                              o_rsp.found_value, want.found_value));
                if (o_rsp.found_index !== want.found_index)
                    report_mismatch($sformatf("found_index got %0d want %0d",
                                              o_rsp.found_index, want.found_index));
                if (o_rsp.length !== want.length)
                    report_mismatch($sformatf("length got %0d want %0d",
                                              o_rsp.length, want.length));
            end
        end
    end

    // watchdog: too long with no beat accepted on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_done) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("timeout after %0d idle cycles", quiet_cycles);
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        gap_cap = 7;
        test_empty_list();
        wait_for_results();
        test_insert_delete_edges();
        wait_for_results();
        test_first_match();
        wait_for_results();
        test_fill_and_drain();
        wait_for_results();
        // catch any stray response beat
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (error_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

### files.f
+incdir+hw/rtl
hw/rtl/olst_pkg.sv
hw/rtl/olst_cell.sv
hw/rtl/olst_ctrl.sv
hw/rtl/ordered_list_store_top.sv
bench/ordered_list_store_top_tb.sv
